[rtl/core/lpht_pkg.sv]
`timescale 1ns / 1ps
package lpht_pkg;

  // slot count; the home slot is taken from the low hash bits, so a power of two
  localparam int unsigned SLOTS = 64;

  typedef enum logic [1:0] {
    CMD_SET = 2'd0,
    CMD_GET = 2'd1,
    CMD_DEL = 2'd2,
    CMD_NOP = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_HIT  = 2'd0,
    ST_NEW  = 2'd1,
    ST_MISS = 2'd2,
    ST_FULL = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    MARK_EMPTY = 2'd0,
    MARK_FULL  = 2'd1,
    MARK_TOMB  = 2'd2,
    MARK_RSVD  = 2'd3
  } mark_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] key;
    logic [31:0] key_hash;
    logic [63:0] value_in;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] value_out;
  } rsp_t;

endpackage

[rtl/core/lpht_front.sv]
`timescale 1ns / 1ps
// Request intake: a small queue of requests waiting for the probe engine.
module lpht_front #(
  parameter int unsigned Depth = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  lpht_pkg::req_t req_i,
  input  logic          push,
  output logic          full,
  output lpht_pkg::req_t req_o,
  output logic          valid_o,
  input  logic          take_i
);
  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;

  lpht_pkg::req_t     mem_q [Depth];
  logic [Aw-1:0]      wptr_q, rptr_q;
  logic [Aw:0]        cnt_q;
  logic               do_push, do_pop;

  assign full    = (cnt_q == (Aw+1)'(Depth));
  assign valid_o = (cnt_q != '0);
  assign req_o   = mem_q[rptr_q];
  assign do_push = push && !full;
  assign do_pop  = take_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= req_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) wptr_q <= (wptr_q == Aw'(Depth - 1)) ? '0 : wptr_q + 1'b1;
      if (do_pop)  rptr_q <= (rptr_q == Aw'(Depth - 1)) ? '0 : rptr_q + 1'b1;
      cnt_q <= cnt_q + (Aw+1)'(do_push) - (Aw+1)'(do_pop);
    end
  end
endmodule

[rtl/core/lpht_back.sv]
`timescale 1ns / 1ps
// Probe engine: walks slots one at a time (S_READ, then S_PROBE per slot), then writes and answers.
module lpht_back #(
  parameter int unsigned LoadLimit = 48
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  lpht_pkg::req_t req_i,
  input  logic           valid_i,
  output logic           take_o,
  output lpht_pkg::rsp_t rsp_o,
  output logic           empty,
  input  logic           pop
);
  localparam int unsigned Aw = $clog2(lpht_pkg::SLOTS);
  localparam int unsigned Cw = $clog2(lpht_pkg::SLOTS + 1);

  typedef enum logic [1:0] {S_IDLE, S_READ, S_PROBE, S_DONE} state_e;

  logic [31:0]          key_mem [lpht_pkg::SLOTS];
  logic [63:0]          val_mem [lpht_pkg::SLOTS];
  lpht_pkg::mark_e      mark_q  [lpht_pkg::SLOTS];
  logic [Cw-1:0]        used_q;

  state_e               state_q;
  lpht_pkg::req_t       cur_q;
  logic [Aw-1:0]        idx_q, tomb_q;
  logic                 have_tomb_q;
  logic [Cw-1:0]        n_q;
  logic [31:0]          rkey_q;
  logic [63:0]          rval_q;
  lpht_pkg::mark_e      mark_rd_q;
  lpht_pkg::rsp_t       rsp_q;
  logic                 out_v_q;

  logic                 wr_en, wr_tomb;
  logic [Aw-1:0]        wr_idx;
  lpht_pkg::mark_e      m;

  assign take_o = (state_q == S_IDLE) && valid_i && !out_v_q;
  assign empty  = !out_v_q;
  assign rsp_o  = rsp_q;
  assign m      = mark_rd_q;

  // Synchronous read of key and value at the probe pointer.
  always_ff @(posedge clk_i) begin
    rkey_q    <= key_mem[idx_q];
    rval_q    <= val_mem[idx_q];
    mark_rd_q <= mark_q[idx_q];
    if (wr_en) begin
      key_mem[wr_idx] <= cur_q.key;
      val_mem[wr_idx] <= cur_q.value_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < lpht_pkg::SLOTS; i++) mark_q[i] <= lpht_pkg::MARK_EMPTY;
      used_q <= '0;
    end else begin
      if (wr_en) mark_q[wr_idx] <= lpht_pkg::MARK_FULL;
      if (wr_tomb) mark_q[idx_q] <= lpht_pkg::MARK_TOMB;
      if (wr_en && state_q == S_PROBE && m == lpht_pkg::MARK_EMPTY && !have_tomb_q)
        used_q <= used_q + 1'b1;
    end
  end

  // Decide writes for this probe step
  always_comb begin
    wr_en   = 1'b0;
    wr_tomb = 1'b0;
    wr_idx  = idx_q;
    if (state_q == S_PROBE) begin
      if (m == lpht_pkg::MARK_FULL && rkey_q == cur_q.key) begin
        wr_en   = (cur_q.cmd == lpht_pkg::CMD_SET);
        wr_tomb = (cur_q.cmd == lpht_pkg::CMD_DEL);
      end else if (m == lpht_pkg::MARK_EMPTY ||
                   n_q == Cw'(lpht_pkg::SLOTS - 1)) begin
        // miss: set into first tombstone, else the empty slot
        if (cur_q.cmd == lpht_pkg::CMD_SET) begin
          if (have_tomb_q) begin
            wr_en = 1'b1; wr_idx = tomb_q;
          end else if (m == lpht_pkg::MARK_EMPTY) begin
            wr_en = 1'b1;
          end else if (m != lpht_pkg::MARK_FULL) begin
            wr_en = 1'b1;  // last slot is itself the first tombstone
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_v_q     <= 1'b0;
      have_tomb_q <= 1'b0;
      n_q         <= '0;
      idx_q       <= '0;
      tomb_q      <= '0;
      cur_q       <= '0;
      rsp_q       <= '0;
    end else begin
      if (pop && out_v_q) out_v_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (take_o) begin
            cur_q       <= req_i;
            idx_q       <= req_i.key_hash[Aw-1:0];
            n_q         <= '0;
            have_tomb_q <= 1'b0;
            state_q     <= S_READ;
          end
        end
        S_READ: begin
          rsp_q.value_out <= '0;
          if (cur_q.cmd == lpht_pkg::CMD_SET &&
              (32'(used_q) + 32'd1) > LoadLimit) begin
            rsp_q.status <= lpht_pkg::ST_FULL;
            state_q      <= S_DONE;
          end else if (cur_q.cmd == lpht_pkg::CMD_NOP ||
                       (cur_q.cmd != lpht_pkg::CMD_SET && used_q == '0)) begin
            rsp_q.status <= lpht_pkg::ST_MISS;
            state_q      <= S_DONE;
          end else begin
            state_q <= S_PROBE;
          end
        end
        S_PROBE: begin
          if (m == lpht_pkg::MARK_FULL && rkey_q == cur_q.key) begin
            rsp_q.status    <= lpht_pkg::ST_HIT;
            rsp_q.value_out <= (cur_q.cmd == lpht_pkg::CMD_GET) ? rval_q : '0;
            state_q         <= S_DONE;
          end else if (m == lpht_pkg::MARK_EMPTY ||
                       n_q == Cw'(lpht_pkg::SLOTS - 1)) begin
            if (cur_q.cmd != lpht_pkg::CMD_SET) rsp_q.status <= lpht_pkg::ST_MISS;
            else if (wr_en) rsp_q.status <= lpht_pkg::ST_NEW;
            else            rsp_q.status <= lpht_pkg::ST_FULL;
            state_q <= S_DONE;
          end else begin
            if (m != lpht_pkg::MARK_FULL && !have_tomb_q) begin
              have_tomb_q <= 1'b1;
              tomb_q      <= idx_q;
            end
            idx_q   <= idx_q + 1'b1;
            n_q     <= n_q + 1'b1;
            state_q <= S_READ;
          end
        end
        S_DONE: begin
          out_v_q <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

[rtl/core/linear_probe_hash_table_top.sv]
`timescale 1ns / 1ps
// Channel   Direction  Ports
// request   in         push, full, req_i (cmd, key, key_hash, value_in)
// result    out        empty, pop, rsp_o (status, value_out)
// A probing request walks P slots from its home slot, P from 1 to SLOTS;
// each probe step is one registered read of the key/value/mark memory.
// Early answers (table full, empty table, NOP) skip the probe: S_READ goes straight to S_DONE.
// Reset clears all slot marks and the occupancy count at once.
// A waiting result holds the engine; two requests queue in front meanwhile.
module linear_probe_hash_table_top #(
  parameter int unsigned LOAD_LIMIT = 48
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push,
  output logic           full,
  input  lpht_pkg::req_t req_i,
  output logic           empty,
  input  logic           pop,
  output lpht_pkg::rsp_t rsp_o
);
  lpht_pkg::req_t q_req;
  logic           q_valid, q_take;

  lpht_front #(.Depth(2)) u_front (
    .clk_i, .rst_ni, .req_i, .push, .full,
    .req_o(q_req), .valid_o(q_valid), .take_i(q_take)
  );

  lpht_back #(.LoadLimit(LOAD_LIMIT)) u_back (
    .clk_i, .rst_ni, .req_i(q_req), .valid_i(q_valid), .take_o(q_take),
    .rsp_o, .empty, .pop
  );

  a_nonget_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && rsp_o.status != lpht_pkg::ST_HIT |-> rsp_o.value_out == '0)
    else $error("value on non-hit");
  a_take_needs_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_take |-> q_valid) else $error("take without request");
  a_no_take_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_take |-> empty) else $error("take while result waits");
endmodule
